// ===== src/window_mean_change_detector_core_assert.svh =====
// assertion macros shared by the checker
`ifndef WINDOW_MEAN_CHANGE_DETECTOR_CORE_ASSERT_SVH
`define WINDOW_MEAN_CHANGE_DETECTOR_CORE_ASSERT_SVH

// antecedent implies consequent on the same edge
`define WMCD_ASSERT_SAME(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("wmcd same-cycle check failed");

// antecedent implies consequent on the next edge
`define WMCD_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("wmcd next-cycle check failed");

`endif

// ===== src/wmcd_pkg.sv =====
`default_nettype none
package wmcd_pkg;

  // sizes
  localparam int SAMPLE_W   = 16;
  localparam int MAX_WINDOW = 4096;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int REM_W      = CNT_W + 1;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int WL_W       = 13;
  localparam int THR_W      = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;

  // register reset values
  localparam logic [WL_W-1:0]  WL_RESET  = 13'd16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd100;

  // controller state
  typedef enum logic [2:0] {
    S_ACC  = 3'b001,
    S_DIV  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_close;
    logic div_done;
    logic out_free;
  } status_t;

  // window length with zero and overlarge values folded in
  function automatic logic [CNT_W-1:0] eff_len(input logic [WL_W-1:0] wl);
    logic [CNT_W-1:0] r;
    if (wl == '0) begin
      r = CNT_W'(1);
    end else if (32'(wl) > MAX_WINDOW) begin
      r = CNT_W'(MAX_WINDOW);
    end else begin
      r = CNT_W'(wl);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/wmcd_ctrl.sv =====
`default_nettype none
module wmcd_ctrl
  import wmcd_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // command decode
  always_comb begin
    in_tready    = (state_r == S_ACC);
    cmd.accept   = in_tvalid && (state_r == S_ACC);
    cmd.div_step = (state_r == S_DIV);
    cmd.publish  = (state_r == S_WAIT) && status.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACC: begin
        if (cmd.accept && status.win_close) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (status.out_free) state_nxt = S_ACC;
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/wmcd_datapath.sv =====
`default_nettype none
module wmcd_datapath
  import wmcd_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire [SAMPLE_W-1:0]     sample,
  input  wire                    end_of_series,
  input  wire                    out_tready,
  output logic                   out_tvalid,
  output logic [3*OUT_W-1:0]     out_tdata,
  output logic [1:0]             out_tuser,
  input  cmd_t                   cmd,
  output status_t                status
);

  // configuration
  logic [WL_W-1:0]  wl_r;
  logic [THR_W-1:0] thr_r;

  // series state
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-2:0] cnt_r;
  logic [OUT_W-1:0] prev_r;
  logic             have_r;
  logic [OUT_W-1:0] win_r;

  // divider
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvsr_r;
  logic [STEP_W-1:0] step_r;
  logic              eos_r;

  // result word
  logic             out_valid_r;
  logic [OUT_W-1:0] o_num_r, o_mean_r, o_diff_r;
  logic             o_cmp_r, o_noise_r;

  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  logic [OUT_W-1:0] mean;
  logic [OUT_W-1:0] diff;
  logic             noise;

  // accumulate and window close test
  always_comb begin
    sum_new = sum_r + SUM_W'(sample);
    cnt_new = {1'b0, cnt_r} + CNT_W'(1);
    status.win_close = (cnt_new >= eff_len(wl_r));
    status.div_done  = (step_r == STEP_W'(SUM_W - 1));
    status.out_free  = !out_valid_r || out_tready;
  end

  // one restoring division step
  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, dvsr_r});
  end

  // mean, difference and noise flag from the finished quotient
  always_comb begin
    mean  = (|quo_r[SUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : quo_r[OUT_W-1:0];
    diff  = '0;
    noise = 1'b0;
    if (have_r) begin
      diff  = (mean >= prev_r) ? (mean - prev_r) : (prev_r - mean);
      noise = (diff > thr_r);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= WL_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_WINDOW_LENGTH:    wl_r  <= cfg_wdata[WL_W-1:0];
        REG_CHANGE_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      prev_r <= '0;
      have_r <= 1'b0;
      win_r  <= '0;
    end else begin
      if (cmd.accept) begin
        if (status.win_close) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else if (end_of_series) begin
          sum_r  <= '0;
          cnt_r  <= '0;
          prev_r <= '0;
          have_r <= 1'b0;
          win_r  <= '0;
        end else begin
          sum_r <= sum_new;
          cnt_r <= cnt_new[CNT_W-2:0];
        end
      end
      if (cmd.publish) begin
        if (eos_r) begin
          prev_r <= '0;
          have_r <= 1'b0;
          win_r  <= '0;
        end else begin
          prev_r <= mean;
          have_r <= 1'b1;
          win_r  <= win_r + OUT_W'(1);
        end
      end
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.accept && status.win_close) begin
      quo_r  <= sum_new;
      rem_r  <= '0;
      dvsr_r <= cnt_new;
      step_r <= '0;
      eos_r  <= end_of_series;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_W-2:0], rem_ge};
      rem_r  <= rem_ge ? CNT_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[CNT_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_num_r   <= win_r;
      o_mean_r  <= mean;
      o_diff_r  <= diff;
      o_cmp_r   <= have_r;
      o_noise_r <= noise;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_diff_r, o_mean_r, o_num_r};
  assign out_tuser  = {o_noise_r, o_cmp_r};

endmodule
`default_nettype wire

// ===== src/window_mean_change_detector_core.sv =====
// result: a sample that closes a window starts 28 divider steps, after which the
//   result word is registered once the output is free
// throughput: one sample per cycle inside a window; the closing sample holds
//   in_tready low through the division, longer while the previous result waits
// reset: synchronous active-low rst_n clears the series, the divider control and
//   the output valid; window_length returns to 16 and change_threshold to 100
`default_nettype none
module window_mean_change_detector_core
  import wmcd_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  // configuration
  input  wire                  cfg_wr_en,
  input  wire [CFG_ADDR_W-1:0] cfg_addr,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  // sample stream
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire [SAMPLE_W-1:0]   in_tdata,   // sample
  input  wire                  in_tlast,   // end_of_series
  // result stream
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [3*OUT_W-1:0]   out_tdata,  // window_number, window_mean, mean_difference
  output logic [1:0]           out_tuser   // compared, noise_found
);

  cmd_t    cmd;
  status_t status;

  wmcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wmcd_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .sample        (in_tdata),
    .end_of_series (in_tlast),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
`default_nettype wire

// ===== src/wmcd_checker.sv =====
`default_nettype none
`include "window_mean_change_detector_core_assert.svh"
module wmcd_checker
  import wmcd_pkg::*;
(
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_tvalid,
  input wire                 out_tready,
  input wire [3*OUT_W-1:0]   out_tdata,
  input wire [1:0]           out_tuser
);

  // result word fields
  logic [OUT_W-1:0] diff_f;
  logic             cmp_f;
  logic             noise_f;

  assign diff_f  = out_tdata[3*OUT_W-1:2*OUT_W];
  assign cmp_f   = out_tuser[0];
  assign noise_f = out_tuser[1];

  // reset empties the output
  `WMCD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_tvalid)

  // a stalled result word stays
  `WMCD_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid)

  // first window of a series carries no difference and no noise
  `WMCD_ASSERT_SAME(a_first_window, clk, !rst_n, out_tvalid && !cmp_f, diff_f == '0 && !noise_f)

  // noise is flagged only with a non-zero difference
  `WMCD_ASSERT_SAME(a_noise_diff, clk, !rst_n, out_tvalid && noise_f, cmp_f && diff_f != '0)

endmodule

bind window_mean_change_detector_core wmcd_checker u_wmcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
